[hw/rtl/gsc_pkg.sv]
// ----------------------------------------------------------------------------
// gsc_pkg: shared types and constants for the region size block
// Holds field widths, request and direction codes, and the control structs
// that pass between the top level and the fill sequencer.
// ----------------------------------------------------------------------------
package gsc_pkg;

	localparam int POS_W   = 3;
	localparam int COLOR_W = 3;
	localparam int COINS_W = 8;
	localparam int SIZE_W  = 7;

	// Region count saturates at the largest value the result field can carry.
	localparam logic [SIZE_W-1:0] SIZE_SAT = 7'd127;

	// Request codes carried on req_type.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Neighbor directions, in the order the fill visits them.
	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	// Step counter value at which all four neighbors have been issued.
	localparam logic [2:0] NBR_STEPS = 3'd4;

	typedef struct packed {
		logic               req_type;
		logic [POS_W-1:0]   row;
		logic [POS_W-1:0]   col;
		logic [COLOR_W-1:0] color;
	} job_t;

	typedef struct packed {
		logic start;
		logic done_ready;
	} seq_ctl_t;

	typedef struct packed {
		logic              idle;
		logic              done_valid;
		logic [SIZE_W-1:0] size;
	} seq_stat_t;

endpackage

[hw/rtl/gsc_nbr_unit.sv]
// ----------------------------------------------------------------------------
// gsc_nbr_unit: neighbor step unit
// Steps one cell in a given direction, flags steps that leave the grid, and
// forms the linear cell index of the neighbor.
// ----------------------------------------------------------------------------
module gsc_nbr_unit
	import gsc_pkg::*;
#(
	parameter int GRID_SIDE = 8,
	parameter int RW        = 3,
	parameter int CELL_W    = 6
) (
	input  logic [RW-1:0]     cur_row,
	input  logic [RW-1:0]     cur_col,
	input  dir_t              dir,
	output logic [RW-1:0]     nbr_row,
	output logic [RW-1:0]     nbr_col,
	output logic [CELL_W-1:0] nbr_idx,
	output logic              nbr_ok
);

	localparam logic [RW-1:0]     LAST = RW'(GRID_SIDE - 1);
	localparam logic [CELL_W-1:0] SIDE = CELL_W'(GRID_SIDE);

	always_comb begin
		nbr_row = cur_row;
		nbr_col = cur_col;
		nbr_ok  = 1'b1;
		case (dir)
			DIR_UP: begin
				nbr_ok  = (cur_row != '0);
				nbr_row = cur_row - RW'(1);
			end
			DIR_DOWN: begin
				nbr_ok  = (cur_row != LAST);
				nbr_row = cur_row + RW'(1);
			end
			DIR_LEFT: begin
				nbr_ok  = (cur_col != '0);
				nbr_col = cur_col - RW'(1);
			end
			DIR_RIGHT: begin
				nbr_ok  = (cur_col != LAST);
				nbr_col = cur_col + RW'(1);
			end
			default: begin
				nbr_ok = 1'b0;
			end
		endcase
	end

	assign nbr_idx = CELL_W'(nbr_row) * SIDE + CELL_W'(nbr_col);

endmodule

[hw/rtl/gsc_fill_seq.sv]
// ----------------------------------------------------------------------------
// gsc_fill_seq: grid store and flood fill sequencer
// Owns the cell color, visited and pending stack memories and walks the
// connected region one popped cell and one neighbor at a time.
// ----------------------------------------------------------------------------
module gsc_fill_seq
	import gsc_pkg::*;
#(
	parameter int GRID_SIDE   = 8,
	parameter int STACK_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_ctl_t  ctl,
	input  job_t      job,
	output seq_stat_t stat
);

	localparam int RW         = $clog2(GRID_SIDE);
	localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int SA_W       = $clog2(STACK_DEPTH);
	localparam int ST_W       = $clog2(STACK_DEPTH + 1);
	localparam int ENT_W      = 2 * RW;

	localparam logic [CELL_W-1:0] CLR_LAST = CELL_W'(CELL_COUNT - 1);
	localparam logic [CELL_W-1:0] SIDE     = CELL_W'(GRID_SIDE);

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_VCLR,
		ST_SEED_RD,
		ST_SEED_CHK,
		ST_POP,
		ST_POPW,
		ST_NBR
	} state_t;

	// While the finished flag is set the sequencer holds its state and offers
	// the count until the top level takes it.
	state_t state_q;
	logic   done_q;

	logic [CELL_W-1:0]  clr_q;
	logic [ST_W-1:0]    top_q;
	logic [SIZE_W-1:0]  count_q;
	logic [2:0]         k_q;
	logic [COLOR_W-1:0] want_q;
	logic [RW-1:0]      seed_row_q;
	logic [RW-1:0]      seed_col_q;
	logic [CELL_W-1:0]  seed_idx_q;
	logic [RW-1:0]      cur_row_q;
	logic [RW-1:0]      cur_col_q;
	logic               p_ok_q;
	logic [RW-1:0]      p_row_q;
	logic [RW-1:0]      p_col_q;
	logic [CELL_W-1:0]  p_idx_q;

	logic [COLOR_W-1:0] cell_mem [CELL_COUNT];
	logic               vis_mem [CELL_COUNT];
	logic [ENT_W-1:0]   stk_mem [STACK_DEPTH];

	logic [COLOR_W-1:0] cell_rd_q;
	logic               vis_rd_q;
	logic [ENT_W-1:0]   stk_rd_q;

	logic               cell_we;
	logic [CELL_W-1:0]  cell_wa;
	logic [COLOR_W-1:0] cell_wd;
	logic               vis_we;
	logic [CELL_W-1:0]  vis_wa;
	logic               vis_wd;
	logic               rd_en;
	logic [CELL_W-1:0]  rd_addr;
	logic               stk_we;
	logic [SA_W-1:0]    stk_wa;
	logic [ENT_W-1:0]   stk_wd;
	logic               stk_re;
	logic [SA_W-1:0]    stk_ra;

	logic               in_grid;
	logic [RW-1:0]      job_row;
	logic [RW-1:0]      job_col;
	logic [CELL_W-1:0]  job_idx;
	logic               push_ok;
	logic               stk_room;

	logic [RW-1:0]      nbr_row;
	logic [RW-1:0]      nbr_col;
	logic [CELL_W-1:0]  nbr_idx;
	logic               nbr_ok;

	assign in_grid = (32'(job.row) < GRID_SIDE) && (32'(job.col) < GRID_SIDE);
	assign job_row = RW'(job.row);
	assign job_col = RW'(job.col);
	assign job_idx = CELL_W'(job_row) * SIDE + CELL_W'(job_col);
	assign stk_room = (32'(top_q) < STACK_DEPTH);

	gsc_nbr_unit #(
		.GRID_SIDE (GRID_SIDE),
		.RW        (RW),
		.CELL_W    (CELL_W)
	) u_nbr (
		.cur_row (cur_row_q),
		.cur_col (cur_col_q),
		.dir     (dir_t'(k_q[1:0])),
		.nbr_row (nbr_row),
		.nbr_col (nbr_col),
		.nbr_idx (nbr_idx),
		.nbr_ok  (nbr_ok)
	);

	// A neighbor checked this cycle joins the region when it is on the grid,
	// not yet marked, of the wanted color, and the stack has room.
	assign push_ok = (state_q == ST_NBR) && !done_q && p_ok_q && !vis_rd_q &&
		(cell_rd_q == want_q) && stk_room;

	always_comb begin
		cell_we = 1'b0;
		cell_wa = clr_q;
		cell_wd = '0;
		vis_we  = 1'b0;
		vis_wa  = clr_q;
		vis_wd  = 1'b0;
		rd_en   = 1'b0;
		rd_addr = nbr_idx;
		stk_we  = 1'b0;
		stk_wa  = SA_W'(top_q);
		stk_wd  = {p_row_q, p_col_q};
		stk_re  = 1'b0;
		stk_ra  = SA_W'(top_q - ST_W'(1));
		if (!done_q) begin
			case (state_q)
				ST_CLR: begin
					cell_we = 1'b1;
					vis_we  = 1'b1;
				end
				ST_IDLE: begin
					if (ctl.start && (job.req_type == REQ_WRITE) && in_grid) begin
						cell_we = 1'b1;
						cell_wa = job_idx;
						cell_wd = job.color;
					end
				end
				ST_VCLR: begin
					vis_we = 1'b1;
				end
				ST_SEED_RD: begin
					rd_en   = 1'b1;
					rd_addr = seed_idx_q;
				end
				ST_SEED_CHK: begin
					if (cell_rd_q == want_q) begin
						stk_we = 1'b1;
						stk_wa = '0;
						stk_wd = {seed_row_q, seed_col_q};
						vis_we = 1'b1;
						vis_wa = seed_idx_q;
						vis_wd = 1'b1;
					end
				end
				ST_POP: begin
					stk_re = (top_q != '0);
				end
				ST_POPW: begin
				end
				ST_NBR: begin
					rd_en = (k_q != NBR_STEPS);
					if (push_ok) begin
						stk_we = 1'b1;
						vis_we = 1'b1;
						vis_wa = p_idx_q;
						vis_wd = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cell_wd;
		end
		if (rd_en) begin
			cell_rd_q <= cell_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_wa] <= vis_wd;
		end
		if (rd_en) begin
			vis_rd_q <= vis_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			done_q     <= 1'b0;
			clr_q      <= '0;
			top_q      <= '0;
			count_q    <= '0;
			k_q        <= '0;
			want_q     <= '0;
			seed_row_q <= '0;
			seed_col_q <= '0;
			seed_idx_q <= '0;
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			p_ok_q     <= 1'b0;
			p_row_q    <= '0;
			p_col_q    <= '0;
			p_idx_q    <= '0;
		end else if (done_q) begin
			if (ctl.done_ready) begin
				done_q  <= 1'b0;
				state_q <= ST_IDLE;
			end
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == CLR_LAST) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (ctl.start) begin
						count_q    <= '0;
						want_q     <= job.color;
						seed_row_q <= job_row;
						seed_col_q <= job_col;
						seed_idx_q <= job_idx;
						clr_q      <= '0;
						if (!in_grid || (job.req_type == REQ_WRITE)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_VCLR;
						end
					end
				end
				ST_VCLR: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == CLR_LAST) begin
						clr_q   <= '0;
						state_q <= ST_SEED_RD;
					end
				end
				ST_SEED_RD: begin
					state_q <= ST_SEED_CHK;
				end
				ST_SEED_CHK: begin
					if (cell_rd_q == want_q) begin
						top_q   <= ST_W'(1);
						state_q <= ST_POP;
					end else begin
						done_q <= 1'b1;
					end
				end
				ST_POP: begin
					if (top_q == '0) begin
						done_q <= 1'b1;
					end else begin
						top_q   <= top_q - ST_W'(1);
						state_q <= ST_POPW;
					end
				end
				ST_POPW: begin
					cur_row_q <= stk_rd_q[ENT_W-1:RW];
					cur_col_q <= stk_rd_q[RW-1:0];
					if (count_q != SIZE_SAT) begin
						count_q <= count_q + SIZE_W'(1);
					end
					k_q     <= '0;
					p_ok_q  <= 1'b0;
					state_q <= ST_NBR;
				end
				ST_NBR: begin
					if (push_ok) begin
						top_q <= top_q + ST_W'(1);
					end
					p_ok_q  <= (k_q != NBR_STEPS) && nbr_ok;
					p_row_q <= nbr_row;
					p_col_q <= nbr_col;
					p_idx_q <= nbr_idx;
					if (k_q == NBR_STEPS) begin
						state_q <= ST_POP;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.idle       = (state_q == ST_IDLE) && !done_q;
	assign stat.done_valid = done_q;
	assign stat.size       = count_q;

endmodule

[hw/rtl/grid_region_size_with_charge.sv]
// ----------------------------------------------------------------------------
// grid_region_size_with_charge: connected region size with coin charge
// Top level with the request and result handshakes, the charge logic and
// the result register in front of the fill sequencer.
// ----------------------------------------------------------------------------
// The block keeps a GRID_SIDE x GRID_SIDE grid of 3-bit cell colors, all
// empty after reset. A write request stores one cell and returns a result of
// all zeros; a request outside the grid also returns zeros. A query request
// names a seed cell, a color and a coin count: when the seed holds that
// color, the block flood fills the 4-connected cells of the color with a
// pending stack of STACK_DEPTH entries and reports their count (saturating at
// 127), the coins paid and whether the coins fell short. One request is
// worked at a time. After reset the block clears its grid before in_ready
// rises. A query first clears the visited marks, one cell per cycle. Every
// popped cell costs one stack read and then one neighbor lookup per cycle
// through the read ports of the cell and visited memories. A finished
// result sits in an output register, so the next request can be taken while
// it waits for out_ready.
module grid_region_size_with_charge
	import gsc_pkg::*;
#(
	parameter int GRID_SIDE   = 8,
	parameter int STACK_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [POS_W-1:0]   row,
	input  logic [POS_W-1:0]   col,
	input  logic [COLOR_W-1:0] color,
	input  logic [COINS_W-1:0] coins,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SIZE_W-1:0]  region_size,
	output logic [SIZE_W-1:0]  coins_paid,
	output logic               eliminated
);

	seq_ctl_t  ctl;
	seq_stat_t stat;
	job_t      job;

	logic [COINS_W-1:0] coins_q;
	logic               out_valid_q;
	logic [SIZE_W-1:0]  region_size_q;
	logic [SIZE_W-1:0]  coins_paid_q;
	logic               eliminated_q;
	logic               short;
	logic               take_done;

	// A request is taken only while the sequencer sits idle.
	assign in_ready = stat.idle;

	assign job.req_type = req_type;
	assign job.row      = row;
	assign job.col      = col;
	assign job.color    = color;

	assign ctl.start      = in_valid && in_ready;
	// The result register frees up when it is empty or being drained.
	assign ctl.done_ready = !out_valid_q || out_ready;
	assign take_done      = stat.done_valid && ctl.done_ready;

	gsc_fill_seq #(
		.GRID_SIDE   (GRID_SIDE),
		.STACK_DEPTH (STACK_DEPTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.job    (job),
		.stat   (stat)
	);

	// The coins fall short when they are fewer than the region. In that case
	// they are below 127 and fit the paid field.
	assign short = (coins_q < {1'b0, stat.size});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coins_q       <= '0;
			out_valid_q   <= 1'b0;
			region_size_q <= '0;
			coins_paid_q  <= '0;
			eliminated_q  <= 1'b0;
		end else begin
			if (ctl.start) begin
				coins_q <= coins;
			end
			if (take_done) begin
				out_valid_q   <= 1'b1;
				region_size_q <= stat.size;
				coins_paid_q  <= short ? coins_q[SIZE_W-1:0] : stat.size;
				eliminated_q  <= short;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign region_size = region_size_q;
	assign coins_paid  = coins_paid_q;
	assign eliminated  = eliminated_q;

endmodule

[hw/rtl/gsc_checker.sv]
// ----------------------------------------------------------------------------
// gsc_checker: port-level checks for the region size block
// Watches the top level's handshakes and result fields over time.
// ----------------------------------------------------------------------------
module gsc_checker
	import gsc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [SIZE_W-1:0] region_size,
	input logic [SIZE_W-1:0] coins_paid,
	input logic              eliminated
);

	// A short payment is always strictly below the region size.
	a_short_pay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && eliminated |-> coins_paid < region_size)
		else $error("eliminated result pays no less than the region size");

	// A covered payment equals the region size.
	a_full_pay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !eliminated |-> coins_paid == region_size)
		else $error("covered result pays other than the region size");

	// Each request occupies the block for at least the following cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken on two back-to-back cycles");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(region_size) &&
		$stable(coins_paid) && $stable(eliminated))
		else $error("stalled result changed or dropped");

endmodule

bind grid_region_size_with_charge gsc_checker u_gsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.region_size (region_size),
	.coins_paid  (coins_paid),
	.eliminated  (eliminated)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for grid_region_size_with_charge
// Writes cells and queries connected regions through the request channel,
// predicts every result with its own flood fill over a private copy of the
// grid, and checks each result in order, idling both channels at random in set phases.
// ----------------------------------------------------------------------------
module tb_top;
	import gsc_pkg::*;

	localparam int SIDE           = 8;
	localparam int CELLS          = SIDE * SIDE;
	localparam int STACK_SLOTS    = 64;
	localparam int RANDOM_ITEMS   = 800;
	localparam int PHASES         = 4;
	// The slowest request is a query over the whole grid: it clears every
	// visited mark and then pops each cell of the region. The limit covers
	// that, the clearing pass after reset and the longest stall many times over.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 600;

	// One expected result: region size, coins paid and the shortfall flag.
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] paid;
		logic              elim;
	} charge_t;

	// Scoreboard: keeps its own copy of the grid, works out the charge of
	// every accepted request and compares results against that in order.
	class region_scoreboard;
		logic [COLOR_W-1:0] cells [CELLS];
		charge_t            owed [$];
		int                 mismatches;
		int                 checked;
		int                 writes;
		int                 queries;
		int                 matched;
		int                 shortfalls;
		int                 widest;

		function new();
			foreach (cells[i]) cells[i] = '0;
			mismatches = 0;
			checked    = 0;
			writes     = 0;
			queries    = 0;
			matched    = 0;
			shortfalls = 0;
			widest     = 0;
		endfunction

		// Depth-first fill from the seed over 4-connected cells of one color.
		// A neighbor found while the stack is full is neither pushed nor
		// marked, so a later path may still pick it up.
		function logic [SIZE_W-1:0] fill_count(int seed, logic [COLOR_W-1:0] want);
			bit                marked [CELLS];
			int                pending [STACK_SLOTS];
			int                depth;
			int                cur;
			int                r;
			int                c;
			int                nr;
			int                nc;
			int                ni;
			logic [SIZE_W-1:0] count;
			foreach (marked[i]) marked[i] = 1'b0;
			count        = '0;
			pending[0]   = seed;
			marked[seed] = 1'b1;
			depth        = 1;
			while (depth > 0) begin
				depth--;
				cur = pending[depth];
				if (count < SIZE_SAT)
					count++;
				r = cur / SIDE;
				c = cur % SIDE;
				for (int d = 0; d < 4; d++) begin
					nr = r;
					nc = c;
					case (dir_t'(d))
						DIR_UP:    nr = r - 1;
						DIR_DOWN:  nr = r + 1;
						DIR_LEFT:  nc = c - 1;
						default:   nc = c + 1;
					endcase
					if (nr < 0 || nr >= SIDE || nc < 0 || nc >= SIDE)
						continue;
					ni = nr * SIDE + nc;
					if (marked[ni] || cells[ni] != want || depth >= STACK_SLOTS)
						continue;
					pending[depth] = ni;
					depth++;
					marked[ni] = 1'b1;
				end
			end
			return count;
		endfunction

		function void note_request(logic kind, logic [POS_W-1:0] r,
				logic [POS_W-1:0] c, logic [COLOR_W-1:0] clr,
				logic [COINS_W-1:0] cn);
			charge_t exp;
			int      idx;
			exp = '0;
			idx = int'(r) * SIDE + int'(c);
			if (kind == REQ_WRITE) begin
				cells[idx] = clr;
				writes++;
			end else begin
				queries++;
				if (cells[idx] == clr) begin
					matched++;
					exp.size = fill_count(idx, clr);
					exp.paid = exp.size;
					if (int'(cn) < int'(exp.size)) begin
						exp.paid = cn[SIZE_W-1:0];
						exp.elim = 1'b1;
						shortfalls++;
					end
					if (int'(exp.size) > widest)
						widest = int'(exp.size);
				end
			end
			owed.push_back(exp);
		endfunction

		function void check_result(logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] paid,
				logic elim);
			charge_t exp;
			checked++;
			if (owed.size() == 0) begin
				if (mismatches < 10)
					$display("result with no request outstanding: %s %0d %0d %0b",
						"size, paid, elim", size, paid, elim);
				mismatches++;
				return;
			end
			exp = owed.pop_front();
			if (size !== exp.size || paid !== exp.paid || elim !== exp.elim) begin
				if (mismatches < 10) begin
					$display("mismatch on result %0d:", checked);
					$display("  expected size %0d paid %0d elim %0b",
						exp.size, exp.paid, exp.elim);
					$display("  got      size %0d paid %0d elim %0b",
						size, paid, elim);
				end
				mismatches++;
			end
		endfunction

		function int failures();
			return mismatches + owed.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               req_type = REQ_WRITE;
	logic [POS_W-1:0]   row = '0;
	logic [POS_W-1:0]   col = '0;
	logic [COLOR_W-1:0] color = '0;
	logic [COINS_W-1:0] coins = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [SIZE_W-1:0]  region_size;
	logic [SIZE_W-1:0]  coins_paid;
	logic               eliminated;

	// Idling is switched off for whole phases, and always for the last one.
	bit                 idle_on = 1'b1;
	region_scoreboard   sb = new();

	grid_region_size_with_charge #(
		.GRID_SIDE   (SIDE),
		.STACK_DEPTH (STACK_SLOTS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.row         (row),
		.col         (col),
		.color       (color),
		.coins       (coins),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.region_size (region_size),
		.coins_paid  (coins_paid),
		.eliminated  (eliminated)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Presents one request and holds it until the block takes it. The task
	// is entered right after an edge, so at most one assignment lands on
	// in_valid per time step: either it drops for a gap, or it stays high.
	task automatic send_request(input logic kind, input int r, input int c,
			input int clr, input int cn);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		row      <= POS_W'(r);
		col      <= POS_W'(c);
		color    <= COLOR_W'(clr);
		coins    <= COINS_W'(cn);
		do @(posedge clk); while (!in_ready);
		sb.note_request(kind, POS_W'(r), POS_W'(c), COLOR_W'(clr), COINS_W'(cn));
	endtask

	// Coin counts: mostly near the sizes a region can reach, so that both
	// sides of the shortfall boundary come up often, plus the full range.
	function automatic int pick_coins();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 255);
			1:       return $urandom_range(0, 8);
			default: return $urandom_range(0, 70);
		endcase
	endfunction

	// Result side: checks every accepted result, and stalls in bursts while
	// idling is on. out_ready is registered from the stall counter.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(region_size, coins_paid, eliminated);
			if (stall_left > 0)
				stall_left--;
			else if (idle_on && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 17);
			out_ready <= (stall_left == 0);
		end
	end

	// Watchdog: ends the run when no request or result moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, sb.owed.size());
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int palette;
		int per_phase;
		int r;
		int c;
		int idx;
		int clr;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The grid starts empty, so a query for color 0
		// covers all 64 cells; the coins around 64 probe the boundary where
		// the charge stops covering the region.
		send_request(REQ_QUERY, 0, 0, 0, 255);
		send_request(REQ_QUERY, 7, 7, 0, 0);
		send_request(REQ_QUERY, 3, 4, 5, 10);
		send_request(REQ_QUERY, 5, 2, 0, 64);
		send_request(REQ_QUERY, 2, 5, 0, 63);

		// Corner cells with colors of their own, and a plus shape of color 3.
		send_request(REQ_WRITE, 0, 0, 7, 255);
		send_request(REQ_WRITE, 7, 7, 7, 0);
		send_request(REQ_WRITE, 0, 7, 1, 128);
		send_request(REQ_WRITE, 7, 0, 2, 0);
		send_request(REQ_WRITE, 3, 3, 3, 0);
		send_request(REQ_WRITE, 2, 3, 3, 0);
		send_request(REQ_WRITE, 4, 3, 3, 0);
		send_request(REQ_WRITE, 3, 2, 3, 0);
		send_request(REQ_WRITE, 3, 4, 3, 0);
		send_request(REQ_QUERY, 3, 3, 3, 5);
		send_request(REQ_QUERY, 4, 3, 3, 4);
		send_request(REQ_QUERY, 0, 0, 7, 1);
		send_request(REQ_QUERY, 7, 7, 7, 0);
		send_request(REQ_QUERY, 0, 1, 0, 128);
		send_request(REQ_QUERY, 0, 7, 6, 255);

		// Erasing the center splits the plus into four single cells.
		send_request(REQ_WRITE, 3, 3, 0, 0);
		send_request(REQ_QUERY, 2, 3, 3, 1);
		send_request(REQ_QUERY, 3, 3, 0, 127);

		// Random part, in phases with palettes of different sizes: a small
		// palette leaves large regions, a wide one leaves many small ones.
		per_phase = RANDOM_ITEMS / PHASES;
		for (int phase = 0; phase < PHASES; phase++) begin
			idle_on = (phase == 0 || phase == 2);
			case (phase)
				0:       palette = 1;
				1:       palette = 3;
				2:       palette = 7;
				default: palette = 2;
			endcase
			for (int n = 0; n < per_phase; n++) begin
				r   = $urandom_range(0, SIDE - 1);
				c   = $urandom_range(0, SIDE - 1);
				idx = r * SIDE + c;
				if ($urandom_range(0, 99) < 45) begin
					if ($urandom_range(0, 9) == 0)
						clr = $urandom_range(0, 7);
					else
						clr = $urandom_range(0, palette);
					send_request(REQ_WRITE, r, c, clr, $urandom_range(0, 255));
				end else begin
					// Most queries name the seed's own color so that a fill
					// runs; the rest may miss.
					if ($urandom_range(0, 4) != 0)
						clr = int'(sb.cells[idx]);
					else
						clr = $urandom_range(0, 7);
					send_request(REQ_QUERY, r, c, clr, pick_coins());
				end
			end
		end
		in_valid <= 1'b0;

		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d writes and %0d queries, %0d of them on a matching seed",
			sb.writes, sb.queries, sb.matched);
		$display("%0d results checked, %0d coin shortfalls, largest region %0d cells",
			sb.checked, sb.shortfalls, sb.widest);
		if (sb.failures() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[grid_region_size_with_charge.f]
hw/rtl/gsc_pkg.sv
hw/rtl/gsc_nbr_unit.sv
hw/rtl/gsc_fill_seq.sv
hw/rtl/grid_region_size_with_charge.sv
hw/rtl/gsc_checker.sv
tb/sv/tb_top.sv
